>>> hw/rtl/cfp_pkg.sv
// shared types, constants and codes of the command frame parser
package cfp_pkg;

  localparam logic [7:0]  SYNC_FIRST_RST = 8'h4C;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h00;
  localparam logic [15:0] MAX_LEN_RST = 16'd1024;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_BADCRC = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    PH_SYNC1   = 8'b0000_0001,
    PH_SYNC2   = 8'b0000_0010,
    PH_OPCODE  = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_LO  = 8'b0100_0000,
    PH_CRC_HI  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  opcode_out;
    logic [15:0] length_out;
    logic        payload_valid;
    logic [7:0]  payload_data;
    logic [15:0] payload_pos;
  } res_t;

endpackage

>>> hw/rtl/cfp_stream_if.sv
// valid/ready stream interface carrying one item payload
interface cfp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/crc_command_frame_parser.sv
// an accepted byte passes the input register, then the result register, to its result item
// one byte per cycle unless stalled; the byte-wide crc update and phase logic sit in one stage
// every accepted byte yields exactly one result item, taken in order
// reset: asynchronous, active low; clears the parser to sync hunt, crc to 0xffff,
// opcode, length and counters to zero, and loads the register defaults
module crc_command_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  cfp_stream_if.sink   rx_i,
  cfp_stream_if.source res_o
);

  cfp_pkg::cfg_t cfg_q;
  cfp_pkg::res_t res_d, res_q;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  logic       out_free;
  logic       step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first      <= cfp_pkg::SYNC_FIRST_RST;
      cfg_q.sync_second     <= cfp_pkg::SYNC_SECOND_RST;
      cfg_q.max_payload_len <= cfp_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfp_pkg::cfg_idx_e'(cfg_idx_i))
        cfp_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first      <= cfg_data_i[7:0];
        cfp_pkg::CFG_SYNC_SECOND: cfg_q.sync_second     <= cfg_data_i[7:0];
        cfp_pkg::CFG_MAX_LEN:     cfg_q.max_payload_len <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_vld_q || res_o.ready;
  assign step       = in_vld_q && out_free;
  assign rx_i.ready = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.data.rx_byte;
    end
  end

  cfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input stalled without a stalled result");

  a_payload_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.payload_valid) |-> (res_o.data.status == cfp_pkg::ST_NONE))
    else $error("payload item carries a frame status");

  a_pos_in_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.payload_valid) |->
      (res_o.data.payload_pos < res_o.data.length_out))
    else $error("payload position beyond frame length");

  a_badlen_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.status == cfp_pkg::ST_BADLEN) |->
      (res_o.data.opcode_out == 8'h00 && res_o.data.length_out == 16'h0000))
    else $error("bad length did not clear the header");

endmodule

>>> hw/rtl/cfp_crc_step.sv
// crc-16/ccitt-false update over one byte, msb first
module cfp_crc_step (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ cfp_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

>>> hw/rtl/cfp_parser.sv
// frame state machine: sync hunt, header with length check, payload streaming and crc check
module cfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  cfp_pkg::cfg_t     cfg_i,
  output cfp_pkg::res_t     res_o
);

  cfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  opc_q, opc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crcl_q, crcl_d;

  logic        crc_restart;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic [15:0] len_new;
  logic [15:0] cnt_inc;

  // in sync hunt a first sync byte starts the crc afresh, unless in PH_SYNC2 it also matches the second sync byte
  assign crc_restart = (phase_q == cfp_pkg::PH_SYNC1) ||
                       ((phase_q == cfp_pkg::PH_SYNC2) && (byte_i != cfg_i.sync_second));
  assign crc_base = crc_restart ? cfp_pkg::CRC_INIT : crc_q;
  assign len_new  = {byte_i, len_q[7:0]};
  assign cnt_inc  = cnt_q + 16'd1;

  cfp_crc_step u_crc (
    .crc_i  (crc_base),
    .byte_i (byte_i),
    .crc_o  (crc_new)
  );

  always_comb begin
    phase_d = phase_q;
    opc_d   = opc_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    crcl_d  = crcl_q;
    res_o.status        = cfp_pkg::ST_NONE;
    res_o.payload_valid = 1'b0;
    res_o.payload_data  = 8'h00;
    res_o.payload_pos   = 16'h0000;
    case (phase_q)
      cfp_pkg::PH_SYNC1: begin
        if (byte_i == cfg_i.sync_first) begin
          crc_d   = crc_new;
          phase_d = cfp_pkg::PH_SYNC2;
        end
      end
      cfp_pkg::PH_SYNC2: begin
        if (byte_i == cfg_i.sync_second) begin
          crc_d   = crc_new;
          phase_d = cfp_pkg::PH_OPCODE;
        end else if (byte_i == cfg_i.sync_first) begin
          crc_d = crc_new;
        end else begin
          phase_d = cfp_pkg::PH_SYNC1;
        end
      end
      cfp_pkg::PH_OPCODE: begin
        opc_d   = byte_i;
        crc_d   = crc_new;
        phase_d = cfp_pkg::PH_LEN_LO;
      end
      cfp_pkg::PH_LEN_LO: begin
        len_d   = {8'h00, byte_i};
        crc_d   = crc_new;
        phase_d = cfp_pkg::PH_LEN_HI;
      end
      cfp_pkg::PH_LEN_HI: begin
        if (len_new > cfg_i.max_payload_len) begin
          // oversized length drops the whole frame context
          phase_d = cfp_pkg::PH_SYNC1;
          opc_d   = 8'h00;
          len_d   = 16'h0000;
          cnt_d   = 16'h0000;
          crc_d   = cfp_pkg::CRC_INIT;
          crcl_d  = 8'h00;
          res_o.status = cfp_pkg::ST_BADLEN;
        end else begin
          len_d   = len_new;
          crc_d   = crc_new;
          cnt_d   = 16'h0000;
          phase_d = (len_new == 16'h0000) ? cfp_pkg::PH_CRC_LO : cfp_pkg::PH_PAYLOAD;
        end
      end
      cfp_pkg::PH_PAYLOAD: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_data  = byte_i;
        res_o.payload_pos   = cnt_q;
        cnt_d = cnt_inc;
        crc_d = crc_new;
        if (cnt_inc >= len_q) begin
          phase_d = cfp_pkg::PH_CRC_LO;
        end
      end
      cfp_pkg::PH_CRC_LO: begin
        crcl_d  = byte_i;
        phase_d = cfp_pkg::PH_CRC_HI;
      end
      cfp_pkg::PH_CRC_HI: begin
        res_o.status = ({byte_i, crcl_q} == crc_q) ? cfp_pkg::ST_OK : cfp_pkg::ST_BADCRC;
        phase_d = cfp_pkg::PH_SYNC1;
        crc_d   = cfp_pkg::CRC_INIT;
      end
      default: begin
        phase_d = cfp_pkg::PH_SYNC1;
      end
    endcase
    res_o.opcode_out = opc_d;
    res_o.length_out = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfp_pkg::PH_SYNC1;
      opc_q   <= 8'h00;
      len_q   <= 16'h0000;
      cnt_q   <= 16'h0000;
      crc_q   <= cfp_pkg::CRC_INIT;
      crcl_q  <= 8'h00;
    end else if (step_i) begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      crcl_q  <= crcl_d;
    end
  end

endmodule
